// ===== hdl/msfill_pkg.sv =====
// Package for the masked SSD patch match and fill core.
// Holds constants, opcodes and the transaction payload structs.
// No dependencies.
package msfill_pkg;

    localparam int MAX_WIDTH_D  = 256;
    localparam int MAX_HEIGHT_D = 256;
    localparam int MAX_RADIUS_D = 15;
    localparam int PIXEL_BITS_D = 16;

    localparam logic [29:0] COST_LIMIT = 30'd999999999;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MATCH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] pixel_value;
        logic        pixel_is_hole;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        pixel_known;
        logic [7:0]  best_x;
        logic [7:0]  best_y;
        logic [29:0] best_cost;
        logic        match_found;
    } res_t;

endpackage

// ===== hdl/masked_ssd_patch_match_fill_core.sv =====
// Top level of the masked SSD patch match and fill core.
// Depends on msfill_pkg for constants and payload types.
//
// A write or read goes from acceptance through S_ACC and S_DONE to the result;
// busy is high meanwhile. A match walks every candidate window through the
// image memory. Each window pixel goes through a target read, a source read
// and the difference. A complete window then waits in S_FWAIT while its cost
// settles and is compared. An original hole in a window cuts it short. The
// fill writes the centre pixel in mode 0, or every unknown pixel of the target
// window in mode 1. The image memory has a single read port. The result
// appears for one cycle on result with done high; it cannot be held off, so it
// must be captured in that cycle. The memory is not cleared by reset.
module masked_ssd_patch_match_fill_core
    import msfill_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_D,
    parameter int MAX_HEIGHT = MAX_HEIGHT_D,
    parameter int MAX_RADIUS = MAX_RADIUS_D,
    parameter int PIXEL_BITS = PIXEL_BITS_D
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output res_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int EW    = PIXEL_BITS + 2;   // pixel, known, hole
    // Signed coordinates wide enough for origin minus radius.
    localparam int CW    = 14;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ACC   = 9'b000000010,
        S_RDT   = 9'b000000100,
        S_RDS   = 9'b000001000,
        S_NEXTW = 9'b000010000,
        S_FWAIT = 9'b000100000,
        S_FRD   = 9'b001000000,
        S_FWR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0] width_reg, height_reg;
    logic [3:0] radius_reg;
    logic       mode_reg;

    // Image memory: {hole, known, pixel}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Effective configuration
    logic [12:0] eff_w, eff_h;
    logic [RW-1:0] eff_r;
    logic [12:0] win_s;
    always_comb
    begin
        eff_w = ({4'd0, width_reg} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, width_reg};
        eff_h = ({4'd0, height_reg} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                       : {4'd0, height_reg};
        eff_r = (int'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        win_s = 13'({eff_r, 1'b0}) + 13'd1;
    end

    cmd_t cmd_reg;
    res_t res_reg, res_next;
    logic done_reg;
    logic accept;

    logic [12:0] i_reg, i_next, j_reg, j_next;   // window origin
    logic [12:0] m_reg, m_next, n_reg, n_next;   // offset in window
    logic [PIXEL_BITS-1:0] tpix_reg, tpix_next;
    logic       tuse_reg, tuse_next;
    logic [47:0] cost_reg, cost_next;
    logic [47:0] best_reg, best_next;
    logic [12:0] bx_reg, bx_next, by_reg, by_next;
    logic        found_reg, found_next;
    logic [PIXEL_BITS:0] diff_reg, diff_next;
    logic        acc_reg, acc_next;
    // Hole bit of the fill target, captured when the target is read.
    logic        hole_keep_reg;

    logic signed [CW-1:0] tx, ty;
    logic        t_in;
    logic [AW-1:0] t_addr, s_addr, c_addr;
    logic [EW-1:0] cmd_entry;
    logic        pos_in;

    assign accept = start && !busy;

    always_comb
    begin
        tx = $signed({1'b0, cmd_reg.pos_x}) - $signed(CW'(eff_r)) + $signed({1'b0, m_reg});
        ty = $signed({1'b0, cmd_reg.pos_y}) - $signed(CW'(eff_r)) + $signed({1'b0, n_reg});
        t_in = (tx >= 0) && (ty >= 0) && (tx < $signed({1'b0, eff_w}))
            && (ty < $signed({1'b0, eff_h}));
        t_addr = {YW'(ty), XW'(tx)};
        s_addr = {YW'(j_reg + n_reg), XW'(i_reg + m_reg)};
        c_addr = {YW'(cmd_reg.pos_y), XW'(cmd_reg.pos_x)};
        pos_in = ({5'd0, cmd_reg.pos_x} < eff_w) && ({5'd0, cmd_reg.pos_y} < eff_h);
        cmd_entry = {cmd_reg.pixel_is_hole, ~cmd_reg.pixel_is_hole,
                     PIXEL_BITS'(cmd_reg.pixel_value)};
    end

    logic last_n, last_m, last_j, last_i;
    always_comb
    begin
        last_n = (n_reg + 13'd1 == win_s);
        last_m = (m_reg + 13'd1 == win_s);
        last_j = (j_reg + 13'd1 + win_s >= eff_h);
        last_i = (i_reg + 13'd1 + win_s >= eff_w);
    end

    logic [PIXEL_BITS-1:0] spix;
    logic [2*PIXEL_BITS+1:0] sq;
    always_comb
    begin
        spix = rdata_reg[PIXEL_BITS-1:0];
        sq   = (2*PIXEL_BITS+2)'(diff_reg) * (2*PIXEL_BITS+2)'(diff_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; m_next = m_reg; n_next = n_reg;
        tpix_next = tpix_reg; tuse_next = tuse_reg;
        cost_next = cost_reg; best_next = best_reg;
        bx_next = bx_reg; by_next = by_reg; found_next = found_reg;
        diff_next = diff_reg; acc_next = 1'b0;
        raddr = t_addr; we = 1'b0; waddr = t_addr; wdata = '0;

        // Squared difference is registered before it is added.
        if (acc_reg)
        begin
            cost_next = cost_reg + 48'(sq);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                raddr = c_addr;
                if (cmd_reg.opcode == OP_WRITE)
                begin
                    we = pos_in;
                    waddr = c_addr;
                    wdata = cmd_entry;
                    state_next = S_DONE;
                end
                else if (cmd_reg.opcode == OP_MATCH)
                begin
                    i_next = '0; j_next = '0; m_next = '0; n_next = '0;
                    best_next = 48'(COST_LIMIT);
                    bx_next = '0; by_next = '0; found_next = 1'b0;
                    cost_next = '0;
                    if (win_s >= eff_w || win_s >= eff_h)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RDT;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RDT:
            begin
                raddr = t_addr;
                tuse_next = t_in;
                state_next = S_RDS;
            end
            S_RDS:
            begin
                // rdata now holds the target; grab it and read the source.
                raddr = s_addr;
                tpix_next = rdata_reg[PIXEL_BITS-1:0];
                tuse_next = tuse_reg & rdata_reg[PIXEL_BITS];
                state_next = S_NEXTW;
            end
            S_NEXTW:
            begin
                if (rdata_reg[PIXEL_BITS+1])
                begin
                    // Original hole in the window: drop this window.
                    m_next = '0; n_next = '0; cost_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        i_next = i_reg + 13'd1;
                    end
                    else
                    begin
                        j_next = j_reg + 13'd1;
                    end
                    state_next = (last_j && last_i) ? S_FRD : S_RDT;
                end
                else
                begin
                    diff_next = (tpix_reg > spix) ? (PIXEL_BITS+1)'(tpix_reg - spix)
                                                  : (PIXEL_BITS+1)'(spix - tpix_reg);
                    if (!tuse_reg)
                    begin
                        diff_next = '0;
                    end
                    acc_next = 1'b1;
                    if (!last_n)
                    begin
                        n_next = n_reg + 13'd1;
                        state_next = S_RDT;
                    end
                    else if (!last_m)
                    begin
                        n_next = '0;
                        m_next = m_reg + 13'd1;
                        state_next = S_RDT;
                    end
                    else
                    begin
                        state_next = S_FWAIT;
                    end
                end
            end
            S_FWAIT:
            begin
                if (!acc_reg)
                begin
                    // Window complete and cost settled: compare.
                    if (cost_reg < best_reg)
                    begin
                        best_next = cost_reg;
                        bx_next = i_reg; by_next = j_reg; found_next = 1'b1;
                    end
                    m_next = '0; n_next = '0; cost_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        i_next = i_reg + 13'd1;
                    end
                    else
                    begin
                        j_next = j_reg + 13'd1;
                    end
                    state_next = (last_j && last_i) ? S_FRD : S_RDT;
                end
            end
            S_FRD:
            begin
                // Start of fill: set up m,n and the source window origin.
                i_next = bx_reg; j_next = by_reg;
                m_next = mode_reg ? 13'd0 : 13'(eff_r);
                n_next = mode_reg ? 13'd0 : 13'(eff_r);
                tuse_next = 1'b0;
                diff_next = '0;
                state_next = found_reg ? S_FWR : S_DONE;
            end
            S_FWR:
            begin
                // Three sub-steps, counted by diff[0] (target read) and tuse (source read).
                if (!tuse_reg && !diff_reg[0])
                begin
                    raddr = t_addr;
                    diff_next = {{PIXEL_BITS{1'b0}}, 1'b1};
                end
                else if (diff_reg[0] && !tuse_reg)
                begin
                    raddr = s_addr;
                    tuse_next = 1'b1;
                    // mode 0 writes even a known centre
                    tpix_next = {{(PIXEL_BITS-1){1'b0}}, ~mode_reg | ~rdata_reg[PIXEL_BITS]};
                end
                else
                begin
                    // The target keeps its hole bit and becomes known.
                    we = t_in && tpix_reg[0];
                    waddr = t_addr;
                    wdata = {hole_keep_reg, 1'b1, rdata_reg[PIXEL_BITS-1:0]};
                    tuse_next = 1'b0;
                    diff_next = '0;
                    if (!mode_reg || (last_n && last_m))
                    begin
                        state_next = S_DONE;
                    end
                    else if (!last_n)
                    begin
                        n_next = n_reg + 13'd1;
                    end
                    else
                    begin
                        n_next = '0;
                        m_next = m_reg + 13'd1;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FWR && diff_reg[0] && !tuse_reg)
        begin
            hole_keep_reg <= rdata_reg[PIXEL_BITS+1];
        end
    end

    always_comb
    begin
        res_next = '0;
        if (cmd_reg.opcode == OP_READ && pos_in)
        begin
            res_next.pixel_out   = 16'(rdata_reg[PIXEL_BITS-1:0]);
            res_next.pixel_known = rdata_reg[PIXEL_BITS];
        end
        if (cmd_reg.opcode == OP_MATCH)
        begin
            res_next.best_x      = 8'(bx_reg);
            res_next.best_y      = 8'(by_reg);
            res_next.best_cost   = 30'(best_reg);
            res_next.match_found = found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            acc_reg    <= 1'b0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            radius_reg <= 4'd5;
            mode_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            done_reg  <= (state_reg == S_DONE);
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_WIDTH:  width_reg  <= pwdata[8:0];
                    REG_HEIGHT: height_reg <= pwdata[8:0];
                    REG_RADIUS: radius_reg <= pwdata[3:0];
                    REG_MODE:   mode_reg   <= pwdata[0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; m_reg <= m_next; n_reg <= n_next;
        tpix_reg <= tpix_next; tuse_reg <= tuse_next;
        cost_reg <= cost_next; best_reg <= best_next;
        bx_reg <= bx_next; by_reg <= by_next; found_reg <= found_next;
        diff_reg <= diff_next;
        if (state_reg == S_IDLE && accept)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_DONE)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {23'd0, height_reg};
            REG_RADIUS: prdata = {28'd0, radius_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE) || done_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== tb/msfill_checker.sv =====
// Checker for the masked SSD patch match and fill core: watches the command,
// result and register channels, predicts each result and compares it.
// Depends on msfill_pkg for the payload structs, opcodes and register indexes.
`timescale 1ns / 1ps

module msfill_checker
    import msfill_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        done,
    input  res_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding,
    output int          matches_hit,
    output int          matches_missed
);

    logic [15:0] pix_mem [0:65535];
    bit          known_mem [0:65535];
    bit          hole_mem [0:65535];

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [3:0]  radius_reg;
    logic        mode_reg;

    res_t pending_outcomes[$];

    function automatic int used_width();
        return (width_reg > MAX_WIDTH_D) ? MAX_WIDTH_D : int'(width_reg);
    endfunction

    function automatic int used_height();
        return (height_reg > MAX_HEIGHT_D) ? MAX_HEIGHT_D : int'(height_reg);
    endfunction

    function automatic bit on_image(int x, int y);
        return x >= 0 && y >= 0 && x < used_width() && y < used_height();
    endfunction

    function automatic int cell_of(int x, int y);
        return y * MAX_WIDTH_D + x;
    endfunction

    // Scans every candidate window and fills the target from the best one.
    function automatic res_t run_patch_match(int px, int py);
        int     w, h, r, s, ox, oy, bx, by, src, tx, ty;
        longint best, cost, d;
        bit     bad, found;
        res_t   res;
        res = '0;
        w = used_width();
        h = used_height();
        r = (radius_reg > MAX_RADIUS_D) ? MAX_RADIUS_D : int'(radius_reg);
        s = 2 * r + 1;
        ox = px - r;
        oy = py - r;
        best = longint'(COST_LIMIT);
        bx = 0;
        by = 0;
        found = 1'b0;
        for (int i = 0; i + s < w; i++)
        begin
            for (int j = 0; j + s < h; j++)
            begin
                bad = 1'b0;
                cost = 0;
                for (int m = 0; m < s && !bad; m++)
                begin
                    for (int n = 0; n < s; n++)
                    begin
                        src = cell_of(i + m, j + n);
                        tx = ox + m;
                        ty = oy + n;
                        if (hole_mem[src])
                        begin
                            bad = 1'b1;
                            break;
                        end
                        if (on_image(tx, ty) && known_mem[cell_of(tx, ty)])
                        begin
                            d = longint'(pix_mem[cell_of(tx, ty)]) - longint'(pix_mem[src]);
                            cost += d * d;
                        end
                    end
                end
                if (!bad && cost < best)
                begin
                    best = cost;
                    bx = i;
                    by = j;
                    found = 1'b1;
                end
            end
        end
        if (found)
        begin
            if (mode_reg == 1'b0)
            begin
                if (on_image(px, py))
                begin
                    pix_mem[cell_of(px, py)] = pix_mem[cell_of(bx + r, by + r)];
                    known_mem[cell_of(px, py)] = 1'b1;
                end
            end
            else
            begin
                // Copies in place, so later pixels may see ones filled just before.
                for (int m = 0; m < s; m++)
                begin
                    for (int n = 0; n < s; n++)
                    begin
                        tx = ox + m;
                        ty = oy + n;
                        if (on_image(tx, ty) && !known_mem[cell_of(tx, ty)])
                        begin
                            pix_mem[cell_of(tx, ty)] = pix_mem[cell_of(bx + m, by + n)];
                            known_mem[cell_of(tx, ty)] = 1'b1;
                        end
                    end
                end
            end
        end
        res.best_x = bx[7:0];
        res.best_y = by[7:0];
        res.best_cost = best[29:0];
        res.match_found = found;
        return res;
    endfunction

    function automatic res_t apply_command(cmd_t c);
        res_t res;
        int   x, y;
        res = '0;
        x = int'(c.pos_x);
        y = int'(c.pos_y);
        case (c.opcode)
            OP_WRITE:
                if (on_image(x, y))
                begin
                    pix_mem[cell_of(x, y)] = c.pixel_value;
                    hole_mem[cell_of(x, y)] = c.pixel_is_hole;
                    known_mem[cell_of(x, y)] = !c.pixel_is_hole;
                end
            OP_MATCH:
            begin
                res = run_patch_match(x, y);
                if (res.match_found)
                    matches_hit++;
                else
                    matches_missed++;
            end
            OP_READ:
                if (on_image(x, y))
                begin
                    res.pixel_out = pix_mem[cell_of(x, y)];
                    res.pixel_known = known_mem[cell_of(x, y)];
                end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 65536; k++)
            begin
                pix_mem[k] = '0;
                known_mem[k] = 1'b0;
                hole_mem[k] = 1'b0;
            end
            width_reg = 9'd256;
            height_reg = 9'd256;
            radius_reg = 4'd5;
            mode_reg = 1'b0;
            pending_outcomes.delete();
            outstanding = 0;
            errors = 0;
            matches_hit = 0;
            matches_missed = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WIDTH:  width_reg = pwdata[8:0];
                    REG_HEIGHT: height_reg = pwdata[8:0];
                    REG_RADIUS: radius_reg = pwdata[3:0];
                    REG_MODE:   mode_reg = pwdata[0];
                    default:    ;
                endcase
            end
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transaction with none expected, actual %h",
                             $time, result);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("pixel_out", want.pixel_out, result.pixel_out);
                    compare_field("pixel_known", want.pixel_known, result.pixel_known);
                    compare_field("best_x", want.best_x, result.best_x);
                    compare_field("best_y", want.best_y, result.best_y);
                    compare_field("best_cost", want.best_cost, result.best_cost);
                    compare_field("match_found", want.match_found, result.match_found);
                end
            end
            if (start && !busy)
                pending_outcomes = {pending_outcomes, apply_command(cmd)};
            outstanding = pending_outcomes.size();
        end
    end

endmodule

// ===== tb/masked_ssd_patch_match_fill_core_test.sv =====
// Testbench top for the masked SSD patch match and fill core: drives commands
// and register writes over several image sizes, radii and fill modes.
// Depends on msfill_pkg, the core and msfill_checker.
`timescale 1ns / 1ps

module masked_ssd_patch_match_fill_core_test;
    import msfill_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    res_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int outstanding;
    int matches_hit;
    int matches_missed;
    int items_sent;
    int quiet_cycles;
    int idle_pct;
    int cur_w;
    int cur_h;
    bit loaded [0:65535];

    masked_ssd_patch_match_fill_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    msfill_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .done           (done),
        .result         (result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .errors         (errors),
        .outstanding    (outstanding),
        .matches_hit    (matches_hit),
        .matches_missed (matches_missed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: any transaction on either channel or the register port restarts it.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("masked_ssd_patch_match_fill_core_test: done, errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic reg_write(logic [1:0] index, int value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(int w, int h, int r, int m);
        wait_idle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_RADIUS, r);
        reg_write(REG_MODE, m);
        cur_w = (w > 256) ? 256 : w;
        cur_h = (h > 256) ? 256 : h;
    endtask

    task automatic issue(logic [1:0] op, int x, int y, int value, bit hole);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        @(negedge clk);
        start = 1'b1;
        cmd.opcode = op;
        cmd.pos_x = x[7:0];
        cmd.pos_y = y[7:0];
        cmd.pixel_value = value[15:0];
        cmd.pixel_is_hole = hole;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_WRITE && x < cur_w && y < cur_h)
            loaded[y * 256 + x] = 1'b1;
        items_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // Loads the whole image in use, with a block of holes to be inpainted.
    task automatic load_image();
        bit hole;
        for (int y = 0; y < cur_h; y++)
        begin
            for (int x = 0; x < cur_w; x++)
            begin
                hole = (x >= 5 && x <= 8 && y >= 5 && y <= 8) || ($urandom_range(99) < 3);
                issue(OP_WRITE, x, y, $urandom_range(65535), hole);
            end
        end
    endtask

    task automatic random_items(int count, bit allow_match);
        int sel;
        int x;
        int y;
        repeat (count)
        begin
            sel = $urandom_range(99);
            if ($urandom_range(99) < 70)
            begin
                x = $urandom_range(cur_w - 1);
                y = $urandom_range(cur_h - 1);
            end
            else
            begin
                x = $urandom_range(255);
                y = $urandom_range(255);
            end
            if (sel < 35 || (sel >= 65 && sel < 92 && !allow_match))
                issue(OP_WRITE, x, y, $urandom_range(65535), $urandom_range(9) == 0);
            else if (sel < 65)
            begin
                // Never read a pixel that has not been written.
                if (x < cur_w && y < cur_h && !loaded[y * 256 + x])
                    issue(OP_WRITE, x, y, $urandom_range(65535), $urandom_range(9) == 0);
                else
                    issue(OP_READ, x, y, $urandom_range(65535), $urandom_range(1));
            end
            else if (sel < 92)
                issue(OP_MATCH, x, y, $urandom_range(65535), $urandom_range(1));
            else
                issue(OP_SPARE, x, y, $urandom_range(65535), $urandom_range(1));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_sent = 0;
        idle_pct = 0;
        cur_w = 256;
        cur_h = 256;
        for (int k = 0; k < 65536; k++)
            loaded[k] = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Smallest image, radius 1, centre-only fill.
        configure(16, 16, 1, 0);
        load_image();
        issue(OP_WRITE, 15, 15, 16'hFFFF, 1'b0);
        issue(OP_WRITE, 0, 0, 0, 1'b0);
        issue(OP_WRITE, 200, 3, 1234, 1'b0);
        issue(OP_READ, 3, 200, 0, 1'b0);
        issue(OP_READ, 15, 15, 0, 1'b0);
        issue(OP_READ, 0, 0, 0, 1'b0);
        issue(OP_READ, 6, 6, 0, 1'b0);
        issue(OP_MATCH, 6, 6, 0, 1'b0);
        issue(OP_READ, 6, 6, 0, 1'b0);
        issue(OP_MATCH, 0, 0, 0, 1'b0);
        issue(OP_MATCH, 255, 255, 0, 1'b0);
        issue(OP_MATCH, 15, 15, 0, 1'b0);
        issue(OP_WRITE, 7, 7, 16'hABCD, 1'b1);
        issue(OP_SPARE, 255, 255, 16'hFFFF, 1'b1);
        issue(OP_READ, 7, 7, 0, 1'b0);
        random_items(20, 1'b1);

        // Same image, every unknown target pixel filled.
        idle_pct = 52;
        configure(16, 16, 1, 1);
        random_items(15, 1'b1);

        // Same image with a wider patch.
        idle_pct = 23;
        configure(16, 16, 2, 1);
        random_items(15, 1'b1);

        // A radius of zero gives a single-pixel window.
        idle_pct = 52;
        configure(16, 16, 0, 0);
        random_items(10, 1'b1);

        // Oversized width register and largest radius: no window fits.
        idle_pct = 0;
        configure(511, 16, 15, 1);
        random_items(10, 1'b1);

        idle_pct = 23;
        configure(16, 256, 15, 0);
        random_items(10, 1'b1);

        wait_idle();
        repeat (20)
            @(negedge clk);
        $display("Sent %0d commands over six register settings, widths 16 to 511,",
                 items_sent);
        $display("radii 0 to 15, both fill modes; %0d matches filled, %0d found no window.",
                 matches_hit, matches_missed);
        if (errors == 0)
            $display("masked_ssd_patch_match_fill_core_test: done, clean");
        else
            $display("masked_ssd_patch_match_fill_core_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/msfill_pkg.sv
hdl/masked_ssd_patch_match_fill_core.sv
tb/msfill_checker.sv
tb/masked_ssd_patch_match_fill_core_test.sv
